// ===== src/sha1md_pkg.sv =====
package sha1md_pkg;

  localparam int unsigned WORDS        = 16;
  localparam int unsigned ROUNDS       = 80;
  localparam int unsigned DIGEST_WORDS = 5;

  typedef logic [6:0] rnd_t;
  typedef logic [2:0] widx_t;
  typedef logic [5:0] bpos_t;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [7:0] PAD_ZERO = 8'h00;
  localparam bpos_t      LEN_POS  = 6'd56;
  localparam bpos_t      LAST_POS = 6'd63;
  localparam rnd_t       LAST_RND = 7'(ROUNDS - 1);
  localparam widx_t      LAST_IDX = 3'(DIGEST_WORDS - 1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       put_byte;
    logic       use_data;
    logic [7:0] pad_byte;
    logic       push_hi;
    logic       push_lo;
    logic       cinit;
    logic       cround;
    logic       cadd;
    rnd_t       rnd;
    logic       load_out;
    widx_t      idx;
    logic       msg_clear;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pos_last;
    logic pos_len;
    logic out_free;
  } sts_t;

  function automatic logic [31:0] iv_word(input widx_t i);
    logic [31:0] v;
    case (i)
      3'd0:    v = 32'h67452301;
      3'd1:    v = 32'hEFCDAB89;
      3'd2:    v = 32'h98BADCFE;
      3'd3:    v = 32'h10325476;
      default: v = 32'hC3D2E1F0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] k_word(input rnd_t r);
    logic [31:0] v;
    if (r < 7'd20) begin
      v = 32'h5A827999;
    end else if (r < 7'd40) begin
      v = 32'h6ED9EBA1;
    end else if (r < 7'd60) begin
      v = 32'h8F1BBCDC;
    end else begin
      v = 32'hCA62C1D6;
    end
    return v;
  endfunction

  function automatic logic [31:0] f_word(input rnd_t r, input logic [31:0] b,
                                         input logic [31:0] c, input logic [31:0] d);
    logic [31:0] v;
    if (r < 7'd20) begin
      v = (b & c) | (~b & d);
    end else if (r < 7'd40) begin
      v = b ^ c ^ d;
    end else if (r < 7'd60) begin
      v = (b & c) | (b & d) | (c & d);
    end else begin
      v = b ^ c ^ d;
    end
    return v;
  endfunction

endpackage

// ===== src/sha1_message_digest.sv =====
// Each accepted message byte is added to the block; a full block is then compressed:
// the working variables are loaded, 80 rounds run on the single round unit, one add.
// A final word adds byte-wise padding and the two 32-bit length words, one or two
// compressions, then the five digest words as the output register frees.
// No new byte is accepted while a block is padded, compressed or read out.
// Reset (rst_n low, synchronous) loads the initial vector and clears the length.
module sha1_message_digest (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] has_byte
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        out_tlast   // last_word
);
  import sha1md_pkg::*;

  // The controller sequences byte loading, padding, the 80 rounds and the digest
  // readout; the datapath holds the 16-word schedule window, the chaining value,
  // the 64-bit length counter and the output register.
  cmd_t        cmd;
  sts_t        sts;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  sha1md_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_has   (in_tuser),
    .in_end   (in_tlast),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The output register lets a new message start while the last digest word
  // still waits to be taken.
  sha1md_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_word  (digest_word),
    .out_idx   (word_index),
    .out_last  (last_word),
    .out_valid (out_tvalid),
    .out_ready (out_tready)
  );

  assign out_tdata = {5'b0, word_index, digest_word};
  assign out_tlast = last_word;

endmodule

// ===== src/sha1md_dp.sv =====
module sha1md_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_byte,
  input  sha1md_pkg::cmd_t    cmd,
  output sha1md_pkg::sts_t    sts,
  output logic [31:0]         out_word,
  output logic [2:0]          out_idx,
  output logic                out_last,
  output logic                out_valid,
  input  logic                out_ready
);
  import sha1md_pkg::*;

  bpos_t       pos_r;
  logic [63:0] len_r;
  logic [23:0] acc_r;
  logic [31:0] win_r [WORDS];
  logic [31:0] var_r [5];
  logic [31:0] chain_r [DIGEST_WORDS];
  logic [31:0] out_word_r;
  widx_t       out_idx_r;
  logic        out_valid_r;

  logic [7:0]  byte_val;
  logic        push;
  logic [31:0] push_word;
  logic [31:0] sched;
  logic [31:0] temp;

  assign byte_val = cmd.use_data ? in_byte : cmd.pad_byte;
  // Next schedule word w[i+16] from the sliding window w[i..i+15].
  assign sched = {win_r[13][30:0] ^ win_r[8][30:0] ^ win_r[2][30:0] ^ win_r[0][30:0],
                  win_r[13][31] ^ win_r[8][31] ^ win_r[2][31] ^ win_r[0][31]};

  assign push = (cmd.put_byte && (pos_r[1:0] == 2'b11)) || cmd.push_hi || cmd.push_lo ||
                cmd.cround;

  always_comb begin
    if (cmd.cround) begin
      push_word = sched;
    end else if (cmd.push_hi) begin
      push_word = len_r[63:32];
    end else if (cmd.push_lo) begin
      push_word = len_r[31:0];
    end else begin
      push_word = {acc_r, byte_val};
    end
  end

  assign temp = {var_r[0][26:0], var_r[0][31:27]} + f_word(cmd.rnd, var_r[1], var_r[2], var_r[3])
              + var_r[4] + k_word(cmd.rnd) + win_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.msg_clear) begin
      pos_r <= '0;
      len_r <= '0;
    end else begin
      if (cmd.put_byte) begin
        pos_r <= pos_r + 6'd1;
      end else if (cmd.push_hi || cmd.push_lo) begin
        pos_r <= pos_r + 6'd4;
      end
      if (cmd.put_byte && cmd.use_data) begin
        len_r <= len_r + 64'd8;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_byte) begin
      acc_r <= {acc_r[15:0], byte_val};
    end
    if (push) begin
      for (int i = 0; i < WORDS - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[WORDS-1] <= push_word;
    end
    if (cmd.cinit) begin
      for (int i = 0; i < 5; i++) begin
        var_r[i] <= chain_r[i];
      end
    end else if (cmd.cround) begin
      var_r[0] <= temp;
      var_r[1] <= var_r[0];
      var_r[2] <= {var_r[1][1:0], var_r[1][31:2]};
      var_r[3] <= var_r[2];
      var_r[4] <= var_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.msg_clear) begin
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        chain_r[i] <= iv_word(3'(i));
      end
    end else if (cmd.cadd) begin
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        chain_r[i] <= chain_r[i] + var_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.load_out) begin
      out_word_r <= chain_r[cmd.idx];
      out_idx_r  <= cmd.idx;
    end
  end

  assign sts.pos_last = (pos_r == LAST_POS);
  assign sts.pos_len  = (pos_r == LEN_POS);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_word  = out_word_r;
  assign out_idx   = out_idx_r;
  assign out_last  = (out_idx_r == LAST_IDX);
  assign out_valid = out_valid_r;

endmodule

// ===== src/sha1md_ctrl.sv =====
module sha1md_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_has,
  input  logic             in_end,
  input  sha1md_pkg::sts_t sts,
  output sha1md_pkg::cmd_t cmd
);
  import sha1md_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_LEN  = 3'd2;
  localparam logic [2:0] S_CINI = 3'd3;
  localparam logic [2:0] S_CRND = 3'd4;
  localparam logic [2:0] S_CADD = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       fin_r, fin_nxt;
  logic       mark_r, mark_nxt;
  logic       final_blk_r, final_blk_nxt;
  rnd_t       rnd_r, rnd_nxt;
  widx_t      idx_r, idx_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    fin_nxt       = fin_r;
    mark_nxt      = mark_r;
    final_blk_nxt = final_blk_r;
    rnd_nxt       = rnd_r;
    idx_nxt       = idx_r;
    cmd           = '0;
    cmd.rnd       = rnd_r;
    cmd.idx       = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.put_byte = in_has;
          cmd.use_data = 1'b1;
          fin_nxt      = in_end;
          mark_nxt     = 1'b0;
          if (in_has && sts.pos_last) begin
            state_nxt = S_CINI;
          end else if (in_end) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (mark_r && sts.pos_len) begin
          cmd.push_hi = 1'b1;
          state_nxt   = S_LEN;
        end else begin
          cmd.put_byte = 1'b1;
          cmd.pad_byte = mark_r ? PAD_ZERO : PAD_MARK;
          mark_nxt     = 1'b1;
          if (sts.pos_last) begin
            state_nxt = S_CINI;
          end
        end
      end
      S_LEN: begin
        cmd.push_lo   = 1'b1;
        final_blk_nxt = 1'b1;
        state_nxt     = S_CINI;
      end
      S_CINI: begin
        cmd.cinit = 1'b1;
        rnd_nxt   = '0;
        state_nxt = S_CRND;
      end
      S_CRND: begin
        cmd.cround = 1'b1;
        rnd_nxt    = rnd_r + 7'd1;
        if (rnd_r == LAST_RND) begin
          state_nxt = S_CADD;
        end
      end
      S_CADD: begin
        cmd.cadd = 1'b1;
        idx_nxt  = '0;
        if (final_blk_r) begin
          state_nxt = S_OUT;
        end else if (fin_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          idx_nxt      = idx_r + 3'd1;
          if (idx_r == LAST_IDX) begin
            cmd.msg_clear = 1'b1;
            fin_nxt       = 1'b0;
            final_blk_nxt = 1'b0;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fin_r       <= 1'b0;
      mark_r      <= 1'b0;
      final_blk_r <= 1'b0;
      rnd_r       <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      fin_r       <= fin_nxt;
      mark_r      <= mark_nxt;
      final_blk_r <= final_blk_nxt;
      rnd_r       <= rnd_nxt;
      idx_r       <= idx_nxt;
    end
  end

  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CRND) |-> (rnd_r <= LAST_RND))
    else $error("round counter beyond last round");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> (idx_r <= LAST_IDX))
    else $error("digest index beyond last word");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!fin_r && !final_blk_r))
    else $error("idle with a message end still pending");

  a_final_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CADD && final_blk_r) |=> (state_r == S_OUT))
    else $error("final block did not lead to digest output");

endmodule
